FILE: rtl/core/ffp_pkg.sv
package ffp_pkg;

	localparam int SAMPLE_W = 32;
	localparam int WEIGHT_W = 16;
	localparam int PROD_W = SAMPLE_W + WEIGHT_W;
	localparam int ACC_W = 64;
	localparam int TAP_W = 5;
	localparam int SHIFT_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 6;
	localparam int BUILTIN_TAPS = 21;

	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESULT_SHIFT = 2'd1;

	localparam logic [TAP_W-1:0] TAP_COUNT_RESET = 5'd21;
	localparam logic [SHIFT_W-1:0] RESULT_SHIFT_RESET = 6'd31;

	localparam logic signed [WEIGHT_W-1:0] WEIGHTS [BUILTIN_TAPS] = '{
		-16'sd1318, -16'sd3829, -16'sd4009, -16'sd717, 16'sd3359, 16'sd2177,
		-16'sd3706, -16'sd5613, 16'sd4154, 16'sd20372, 16'sd28471, 16'sd20372,
		16'sd4154, -16'sd5613, -16'sd3706, 16'sd2177, 16'sd3359, -16'sd717,
		16'sd4009, -16'sd3829, -16'sd1318
	};

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	typedef struct packed {
		logic             clear;
		logic             issue;
		logic             ok;
		logic [TAP_W-1:0] k;
	} mac_ctl_t;

	function automatic logic signed [WEIGHT_W-1:0] tap_weight(input logic [TAP_W-1:0] k);
		logic signed [WEIGHT_W-1:0] w;
		w = '0;
		if (int'(k) < BUILTIN_TAPS) begin
			w = WEIGHTS[k];
		end
		return w;
	endfunction

endpackage

FILE: rtl/core/ffp_ram.sv
module ffp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 21
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/ffp_mac.sv
module ffp_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ffp_pkg::mac_ctl_t                    ctl,
	input  logic [ffp_pkg::SAMPLE_W-1:0]         rd_data,
	input  logic [ffp_pkg::SHIFT_W-1:0]          result_shift,
	output logic                                 busy,
	output logic [ffp_pkg::SAMPLE_W-1:0]         result
);

	import ffp_pkg::*;

	logic                       v_s1;
	logic                       ok_s1;
	logic [TAP_W-1:0]           k_s1;
	logic                       v_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] operand;
	logic signed [ACC_W-1:0]    shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1 <= ctl.ok;
		k_s1 <= ctl.k;
	end

	// Entries of the delay line that were never written read as zero.
	assign operand = ok_s1 ? $signed(rd_data) : '0;

	always_ff @(posedge clk) begin
		prod_s2 <= operand * tap_weight(k_s1);
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	assign shifted = acc_q >>> result_shift;
	assign result = shifted[SAMPLE_W-1:0];
	assign busy = v_s1 | v_s2;

endmodule

FILE: rtl/core/fir_filter_fixed_point_unit.sv
// Direct-form FIR filter on signed 32-bit samples with a circular delay line held in a
// single dual-port RAM. Each accepted sample is written into the delay line, then one
// shared 32x16 multiplier and a 64-bit accumulator walk the taps in use, one RAM read
// a cycle, and the sum is shifted right arithmetically by result_shift before its low
// 32 bits are returned. The taps in use are n, tap_count clamped to 1..TAPS. The one
// RAM read port feeds the single multiply-accumulate, and in_stall is high outside
// idle, so a sample is accepted only after the previous one has walked its taps,
// drained the multiply-accumulate pipeline and found the output register free.
// The next sample is accepted as soon as the previous one has finished, even while its
// result waits to be taken.
// The delay line reads as zero after reset through per-entry valid flags, so there is
// no clearing pass. Configuration must only be written while the filter is idle.
module fir_filter_fixed_point_unit #(
	parameter int TAPS = 21
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ffp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ffp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ffp_pkg::SAMPLE_W-1:0]    sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ffp_pkg::SAMPLE_W-1:0]    filtered_sample
);

	import ffp_pkg::*;

	localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int CW = (AW > TAP_W) ? AW : TAP_W;
	localparam int NMAX = (TAPS < 31) ? TAPS : 31;

	state_t               state_q;
	state_t               state_d;
	logic [TAP_W-1:0]     tap_count_q;
	logic [SHIFT_W-1:0]   result_shift_q;
	logic [AW-1:0]        wp_q;
	logic [AW-1:0]        rd_idx_q;
	logic [TAP_W-1:0]     k_q;
	logic [TAPS-1:0]      valid_q;
	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  out_q;
	logic [TAP_W-1:0]     n;
	logic [AW-1:0]        wp_eff;
	logic [AW-1:0]        wp_next;
	logic                 in_acc;
	logic                 out_free;
	logic                 finish;
	logic                 last_tap;
	mac_ctl_t             ctl;
	logic [SAMPLE_W-1:0]  rd_data;
	logic                 mac_busy;
	logic [SAMPLE_W-1:0]  mac_result;

	always_comb begin
		if (tap_count_q == '0) begin
			n = TAP_W'(1);
		end else if (int'(tap_count_q) > NMAX) begin
			n = TAP_W'(NMAX);
		end else begin
			n = tap_count_q;
		end
	end

	assign wp_eff = (CW'(wp_q) >= CW'(n)) ? '0 : wp_q;
	assign wp_next = (CW'(wp_eff) + CW'(1) >= CW'(n)) ? '0 : wp_eff + AW'(1);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign finish = (state_q == ST_DRAIN) && !mac_busy && out_free;
	assign last_tap = (k_q == n - TAP_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RESET;
			result_shift_q <= RESULT_SHIFT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TAP_COUNT: tap_count_q <= cfg_data[TAP_W-1:0];
				REG_RESULT_SHIFT: result_shift_q <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (last_tap) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q <= '0;
			rd_idx_q <= '0;
			k_q <= '0;
			valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				wp_q <= wp_next;
				rd_idx_q <= wp_eff;
				k_q <= '0;
				valid_q[wp_eff] <= 1'b1;
			end else if (state_q == ST_RUN) begin
				rd_idx_q <= (rd_idx_q == '0) ? AW'(n - TAP_W'(1)) : rd_idx_q - AW'(1);
				k_q <= k_q + TAP_W'(1);
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q <= mac_result;
		end
	end

	assign ctl.clear = in_acc;
	assign ctl.issue = (state_q == ST_RUN);
	assign ctl.ok = valid_q[rd_idx_q];
	assign ctl.k = k_q;

	ffp_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(TAPS)
	) u_history (
		.clk   (clk),
		.we    (in_acc),
		.waddr (wp_eff),
		.wdata (sample),
		.re    (ctl.issue),
		.raddr (rd_idx_q),
		.rdata (rd_data)
	);

	ffp_mac u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.rd_data      (rd_data),
		.result_shift (result_shift_q),
		.busy         (mac_busy),
		.result       (mac_result)
	);

	assign out_valid = out_valid_q;
	assign filtered_sample = out_q;

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mac_busy)
		else $error("multiply-accumulate pipeline busy while idle");

	a_run_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> ((k_q < n) && (CW'(rd_idx_q) < CW'(n))))
		else $error("tap or delay-line index beyond taps in use");

	a_finish_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (out_valid && (filtered_sample == $past(mac_result))))
		else $error("finished result not presented");

endmodule

FILE: tb/fir_filter_fixed_point_unit_tb.sv
`timescale 1ns / 1ps

module fir_filter_fixed_point_unit_tb;
	import ffp_pkg::*;

	localparam int TAPS = 21;
	localparam int QUIET_LIMIT = 5000;
	localparam int RANDOM_PHASES = 14;
	localparam int PHASE_BEATS = 125;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [SAMPLE_W-1:0]   sample;
	logic                  out_valid;
	logic                  out_stall;
	logic [SAMPLE_W-1:0]   filtered_sample;

	logic signed [SAMPLE_W-1:0] history_model [TAPS];
	int unsigned                write_slot;
	logic [TAP_W-1:0]           tap_count_reg;
	logic [SHIFT_W-1:0]         shift_reg;
	logic [SAMPLE_W-1:0]        expected_outputs [$];
	logic [SAMPLE_W-1:0]        oldest_output;
	bit                         jitter_on;
	int                         mismatches;
	int                         quiet_cycles;

	fir_filter_fixed_point_unit #(
		.TAPS(TAPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered_sample(filtered_sample)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [SAMPLE_W-1:0] filter_step(input logic [SAMPLE_W-1:0] value);
		int unsigned n;
		int unsigned idx;
		int unsigned k;
		logic signed [ACC_W-1:0] acc;
		logic signed [ACC_W-1:0] shifted;
		n = tap_count_reg;
		if (n < 1) n = 1;
		if (n > TAPS) n = TAPS;
		if (write_slot >= n) write_slot = 0;
		history_model[write_slot] = value;
		acc = '0;
		for (k = 0; k < n; k++) begin
			idx = (write_slot >= k) ? write_slot - k : write_slot + n - k;
			acc += longint'(history_model[idx]) * longint'(WEIGHTS[k]);
		end
		shifted = acc >>> shift_reg;
		write_slot++;
		if (write_slot >= n) write_slot = 0;
		return shifted[SAMPLE_W-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [SAMPLE_W-1:0] value;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: value = 32'h7FFF_FFFF;
					1: value = 32'h8000_0000;
					2: value = 32'h0000_0000;
					default: value = 32'hFFFF_FFFF;
				endcase
			end
			1, 2: value = $urandom_range(2000) - 1000;
			default: value = $urandom;
		endcase
		return value;
	endfunction

	task automatic flag_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
			input logic [SAMPLE_W-1:0] want);
		$display("%0t mismatch: %s got %h expected %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		while (jitter_on && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		do @(posedge clk); while (in_stall);
		expected_outputs.push_back(filter_step(value));
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (expected_outputs.size() != 0) @(posedge clk);
	endtask

	task automatic program_filter(input logic [CFG_DATA_W-1:0] taps_data,
			input logic [CFG_DATA_W-1:0] shift_data, input bit poke_spare);
		hold_until_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_TAP_COUNT;
		cfg_data <= taps_data;
		@(posedge clk);
		cfg_index <= REG_RESULT_SHIFT;
		cfg_data <= shift_data;
		@(posedge clk);
		if (poke_spare) begin
			cfg_index <= REG_SPARE_2;
			cfg_data <= ~taps_data;
			@(posedge clk);
			cfg_index <= REG_SPARE_3;
			cfg_data <= ~shift_data;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		tap_count_reg = taps_data[TAP_W-1:0];
		shift_reg = shift_data[SHIFT_W-1:0];
	endtask

	task automatic test_reset_extremes();
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0000_0001);
		send_sample(32'h0000_0000);
		send_sample(32'h5555_5555);
		send_sample(32'hAAAA_AAAA);
	endtask

	task automatic test_tap_count_corners();
		// The write slot is left at seven, past the end of a three-tap line.
		program_filter(6'd3, 6'd0, 1'b0);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h1234_5678);
		send_sample(32'hFEDC_BA98);
		program_filter(6'd0, 6'd63, 1'b0);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h0000_0001);
		program_filter(6'h3F, 6'd32, 1'b0);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
	endtask

	task automatic test_unused_register_index();
		program_filter(6'd9, 6'd20, 1'b1);
		send_sample(32'h4000_0000);
		send_sample(32'hC000_0000);
	endtask

	task automatic test_random_settings();
		int phase;
		int beat;
		logic [CFG_DATA_W-1:0] taps_data;
		logic [CFG_DATA_W-1:0] shift_data;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					taps_data = 6'd21;
					shift_data = 6'd0;
				end
				1: begin
					taps_data = 6'd1;
					shift_data = 6'd63;
				end
				default: begin
					case ($urandom_range(5))
						0: taps_data = 6'd0;
						1: taps_data = CFG_DATA_W'($urandom_range(63, 22));
						default: taps_data = CFG_DATA_W'($urandom_range(21, 1));
					endcase
					case ($urandom_range(4))
						0: shift_data = 6'd0;
						1: shift_data = 6'd63;
						default: shift_data = CFG_DATA_W'($urandom_range(40, 12));
					endcase
				end
			endcase
			program_filter(taps_data, shift_data, $urandom_range(3) == 0);
			jitter_on = !(phase == 6 || phase == 7);
			for (beat = 0; beat < PHASE_BEATS; beat++) begin
				if (phase % 4 == 2 && beat == PHASE_BEATS / 2) hold_until_drained();
				send_sample(pick_sample());
			end
		end
		jitter_on = 1'b1;
	endtask

	always @(posedge clk) begin
		out_stall <= jitter_on && $urandom_range(99) < 27;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_outputs.size() == 0) begin
				flag_mismatch("filtered_sample with no beat pending", filtered_sample, 'x);
			end else begin
				oldest_output = expected_outputs.pop_front();
				if (filtered_sample !== oldest_output)
					flag_mismatch("filtered_sample", filtered_sample, oldest_output);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("fir_filter_fixed_point_unit_tb NOT OK");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_TAP_COUNT;
		cfg_data <= '0;
		in_valid <= 1'b0;
		sample <= '0;
		jitter_on = 1'b1;
		mismatches = 0;
		tap_count_reg = TAP_COUNT_RESET;
		shift_reg = RESULT_SHIFT_RESET;
		write_slot = 0;
		foreach (history_model[i]) history_model[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_extremes();
		test_tap_count_corners();
		test_unused_register_index();
		test_random_settings();

		hold_until_drained();
		repeat (30) @(posedge clk);
		if (expected_outputs.size() != 0)
			flag_mismatch("beats still pending at end", '0, expected_outputs[0]);
		if (mismatches == 0) begin
			$display("fir_filter_fixed_point_unit_tb OK");
		end else begin
			$display("fir_filter_fixed_point_unit_tb NOT OK");
		end
		$finish;
	end

endmodule
